@@ rtl/vlr_pkg.sv @@
// Shared constants for the van Leer interface reconstruction pipeline.
`timescale 1ns / 1ps

package vlr_pkg;

    // Default fixed-point format of cell values and velocity
    localparam int FRACTION_BITS = 16;
    localparam int VALUE_WIDTH   = 32;

    // Fixed widths of time step and cell width
    localparam int STEP_WIDTH    = 31;
    localparam int DX_WIDTH      = 31;

endpackage

@@ rtl/vlr_div_pipe.sv @@
// Fully pipelined restoring divider, one quotient bit per stage, with side data.
`timescale 1ns / 1ps

module vlr_div_pipe #(
    parameter int QUO_WIDTH  = vlr_pkg::VALUE_WIDTH + 2,
    parameter int DEN_WIDTH  = vlr_pkg::VALUE_WIDTH + 2,
    parameter int SIDE_WIDTH = 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_vld,
    input  logic [DEN_WIDTH-1:0]  in_rem,
    input  logic [QUO_WIDTH-1:0]  in_num,
    input  logic [DEN_WIDTH-1:0]  in_den,
    input  logic [SIDE_WIDTH-1:0] in_side,
    output logic                  out_vld,
    output logic [QUO_WIDTH-1:0]  out_quo,
    output logic [DEN_WIDTH-1:0]  out_rem,
    output logic [DEN_WIDTH-1:0]  out_den,
    output logic [SIDE_WIDTH-1:0] out_side
);

    logic                  vld_reg  [QUO_WIDTH];
    logic [DEN_WIDTH-1:0]  rem_reg  [QUO_WIDTH];
    logic [QUO_WIDTH-1:0]  num_reg  [QUO_WIDTH];
    logic [DEN_WIDTH-1:0]  den_reg  [QUO_WIDTH];
    logic [SIDE_WIDTH-1:0] side_reg [QUO_WIDTH];

    logic [DEN_WIDTH-1:0]  rem_next [QUO_WIDTH];
    logic [QUO_WIDTH-1:0]  num_next [QUO_WIDTH];

    // One trial subtraction per stage; the numerator word shifts left and
    // collects quotient bits at its bottom end
    always_comb
    begin
        logic [DEN_WIDTH-1:0] prv_rem;
        logic [DEN_WIDTH-1:0] prv_den;
        logic [QUO_WIDTH-1:0] prv_num;
        logic [DEN_WIDTH:0]   trial;
        logic [DEN_WIDTH:0]   diff;
        logic                 take;
        for (int k = 0; k < QUO_WIDTH; k++)
        begin
            if (k == 0)
            begin
                prv_rem = in_rem;
                prv_den = in_den;
                prv_num = in_num;
            end
            else
            begin
                prv_rem = rem_reg[k-1];
                prv_den = den_reg[k-1];
                prv_num = num_reg[k-1];
            end
            trial       = {prv_rem, prv_num[QUO_WIDTH-1]};
            diff        = trial - {1'b0, prv_den};
            take        = (trial >= {1'b0, prv_den});
            rem_next[k] = take ? diff[DEN_WIDTH-1:0] : trial[DEN_WIDTH-1:0];
            num_next[k] = {prv_num[QUO_WIDTH-2:0], take};
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < QUO_WIDTH; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else
        begin
            for (int k = 0; k < QUO_WIDTH; k++)
            begin
                vld_reg[k] <= (k == 0) ? in_vld : vld_reg[k-1];
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < QUO_WIDTH; k++)
        begin
            rem_reg[k]  <= rem_next[k];
            num_reg[k]  <= num_next[k];
            den_reg[k]  <= (k == 0) ? in_den  : den_reg[k-1];
            side_reg[k] <= (k == 0) ? in_side : side_reg[k-1];
        end
    end

    assign out_vld  = vld_reg[QUO_WIDTH-1];
    assign out_quo  = num_reg[QUO_WIDTH-1];
    assign out_rem  = rem_reg[QUO_WIDTH-1];
    assign out_den  = den_reg[QUO_WIDTH-1];
    assign out_side = side_reg[QUO_WIDTH-1];

endmodule

@@ rtl/van_leer_x_interface_reconstruct_core.sv @@
// Van Leer slope-limited upwind reconstruction at one x interface, top level.
// Path: stages A and B, the slope divider, stages D, E and F, the correction
//   divider, then stages H, J and K, whose register drives done; the depth is
//   set by the two bit-per-stage dividers (harmonic slope, then correction).
// Throughput: one word per cycle; busy is always low and the result strobe
//   done cannot be held off.
// Reset: rst_n clears all valid bits and the time step register to zero.
`timescale 1ns / 1ps

module van_leer_x_interface_reconstruct_core #(
    parameter int FRACTION_BITS = vlr_pkg::FRACTION_BITS,
    parameter int VALUE_WIDTH   = vlr_pkg::VALUE_WIDTH
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [vlr_pkg::STEP_WIDTH-1:0]        cfg_data,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [VALUE_WIDTH-1:0]         value_two_left,
    input  logic signed [VALUE_WIDTH-1:0]         value_left,
    input  logic signed [VALUE_WIDTH-1:0]         value_here,
    input  logic signed [VALUE_WIDTH-1:0]         value_right,
    input  logic signed [VALUE_WIDTH-1:0]         velocity,
    input  logic [vlr_pkg::DX_WIDTH-1:0]          cell_width,
    output logic                                  done,
    output logic signed [VALUE_WIDTH-1:0]         interface_value,
    output logic                                  saturated
);

    localparam int DTW     = vlr_pkg::STEP_WIDTH;
    localparam int DXW     = vlr_pkg::DX_WIDTH;
    localparam int MW      = VALUE_WIDTH + 1;          // difference magnitude
    localparam int N1W     = 2 * MW + 1;               // 2ab
    localparam int Q1      = VALUE_WIDTH + 2;          // harmonic quotient
    localparam int D1W     = VALUE_WIDTH + 2;          // a+b
    localparam int HW      = VALUE_WIDTH + 2;
    localparam int MTW     = VALUE_WIDTH + DTW;        // |v|*dt
    localparam int DXFW    = DXW + FRACTION_BITS;      // dx in Q2F
    localparam int LW      = (MTW > DXFW) ? MTW : DXFW;
    localparam int LS      = (LW + 1) / 2;
    localparam int LH      = LW - LS;
    localparam int PW      = HW + LW;
    localparam int D2W     = DXFW + 1;
    localparam int Q2      = VALUE_WIDTH + 2;
    localparam int CW      = (LW > D2W) ? LW : D2W;
    localparam int CMW     = VALUE_WIDTH + 2;
    localparam int RW      = VALUE_WIDTH + 4;
    localparam int S1W     = 3 + VALUE_WIDTH + MTW + DXW;
    localparam int S2W     = 4 + VALUE_WIDTH;
    localparam int LATENCY = Q1 + Q2 + 8;

    localparam logic [CMW-1:0] CAP = {1'b1, {(VALUE_WIDTH+1){1'b0}}};
    localparam logic signed [VALUE_WIDTH-1:0] MAX_VAL = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic signed [VALUE_WIDTH-1:0] MIN_VAL = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    // Time step register
    logic [DTW-1:0] ts_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ts_reg <= '0;
        end
        else if (cfg_write)
        begin
            ts_reg <= cfg_data;
        end
    end

    assign busy = 1'b0;

    // Stage A: upwind choice, differences and magnitudes
    logic                   a_pos_next;
    logic [MW-1:0]          dif_a;
    logic [MW-1:0]          dif_b;
    logic [VALUE_WIDTH-1:0] base_next;
    logic [MW-1:0]          ma_next;
    logic [MW-1:0]          mb_next;
    logic                   hzero_next;
    logic [VALUE_WIDTH-1:0] vmag_next;

    always_comb
    begin
        logic [MW-1:0] x2l;
        logic [MW-1:0] xl;
        logic [MW-1:0] xh;
        logic [MW-1:0] xr;
        x2l        = {value_two_left[VALUE_WIDTH-1], value_two_left};
        xl         = {value_left[VALUE_WIDTH-1], value_left};
        xh         = {value_here[VALUE_WIDTH-1], value_here};
        xr         = {value_right[VALUE_WIDTH-1], value_right};
        a_pos_next = !velocity[VALUE_WIDTH-1] && (velocity != '0);
        dif_a      = a_pos_next ? (xl - x2l) : (xh - xl);
        dif_b      = a_pos_next ? (xh - xl) : (xr - xh);
        base_next  = a_pos_next ? value_left : value_here;
        ma_next    = dif_a[MW-1] ? (~dif_a + 1'b1) : dif_a;
        mb_next    = dif_b[MW-1] ? (~dif_b + 1'b1) : dif_b;
        hzero_next = (dif_a == '0) || (dif_b == '0) || (dif_a[MW-1] != dif_b[MW-1]);
        vmag_next  = velocity[VALUE_WIDTH-1] ? (~velocity + 1'b1) : velocity;
    end

    logic                   a_vld_reg;
    logic                   a_pos_reg;
    logic                   a_hneg_reg;
    logic                   a_hzero_reg;
    logic [VALUE_WIDTH-1:0] a_base_reg;
    logic [MW-1:0]          a_ma_reg;
    logic [MW-1:0]          a_mb_reg;
    logic [VALUE_WIDTH-1:0] a_vmag_reg;
    logic [DXW-1:0]         a_dx_reg;

    // Stage B: ab and |v|*dt products and the sum a+b
    logic                   b_vld_reg;
    logic                   b_pos_reg;
    logic                   b_hneg_reg;
    logic                   b_hzero_reg;
    logic [VALUE_WIDTH-1:0] b_base_reg;
    logic [2*MW-1:0]        b_prod_reg;
    logic [D1W-1:0]         b_den_reg;
    logic [MTW-1:0]         b_m_reg;
    logic [DXW-1:0]         b_dx_reg;

    // Stage D: rounded slope term and length
    logic                   d_vld_reg;
    logic                   d_pos_reg;
    logic                   d_skip_reg;
    logic                   d_neg_reg;
    logic [VALUE_WIDTH-1:0] d_base_reg;
    logic [HW-1:0]          d_hmag_reg;
    logic [LW-1:0]          d_len_reg;
    logic [DXW-1:0]         d_dx_reg;

    // Stage E: split product
    logic                   e_vld_reg;
    logic                   e_pos_reg;
    logic                   e_skip_reg;
    logic                   e_neg_reg;
    logic [VALUE_WIDTH-1:0] e_base_reg;
    logic [HW+LS-1:0]       e_pplo_reg;
    logic [HW+LH-1:0]       e_pphi_reg;
    logic [DXW-1:0]         e_dx_reg;

    // Stage F: joined product and divisor
    logic                   f_vld_reg;
    logic                   f_pos_reg;
    logic                   f_skip_reg;
    logic                   f_neg_reg;
    logic [VALUE_WIDTH-1:0] f_base_reg;
    logic [PW-1:0]          f_prod_reg;
    logic [D2W-1:0]         f_d2_reg;

    // Stage H, J, K: rounding, clipping, sum and saturation
    logic                   h_vld_reg;
    logic                   h_pos_reg;
    logic                   h_skip_reg;
    logic                   h_neg_reg;
    logic                   h_ovf_reg;
    logic [VALUE_WIDTH-1:0] h_base_reg;
    logic [Q2:0]            h_q2r_reg;

    logic                   j_vld_reg;
    logic                   j_sub_reg;
    logic [VALUE_WIDTH-1:0] j_base_reg;
    logic [CMW-1:0]         j_cm_reg;

    logic                   done_reg;
    logic [VALUE_WIDTH-1:0] interface_value_reg;
    logic                   saturated_reg;

    // Divider 1: 2ab / (a+b)
    logic [N1W-1:0] num1;
    logic [S1W-1:0] side1_in;
    logic           q1_vld;
    logic [Q1-1:0]  q1_quo;
    logic [D1W-1:0] q1_rem;
    logic [D1W-1:0] q1_den;
    logic [S1W-1:0] q1_side;

    assign num1     = {b_prod_reg, 1'b0};
    assign side1_in = {b_pos_reg, b_hneg_reg, b_hzero_reg, b_base_reg, b_m_reg, b_dx_reg};

    vlr_div_pipe #(
        .QUO_WIDTH  (Q1),
        .DEN_WIDTH  (D1W),
        .SIDE_WIDTH (S1W)
    ) u_div_slope (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (b_vld_reg),
        .in_rem   ({1'b0, num1[N1W-1:Q1]}),
        .in_num   (num1[Q1-1:0]),
        .in_den   (b_den_reg),
        .in_side  (side1_in),
        .out_vld  (q1_vld),
        .out_quo  (q1_quo),
        .out_rem  (q1_rem),
        .out_den  (q1_den),
        .out_side (q1_side)
    );

    logic                   s1_pos;
    logic                   s1_hneg;
    logic                   s1_hzero;
    logic [VALUE_WIDTH-1:0] s1_base;
    logic [MTW-1:0]         s1_m;
    logic [DXW-1:0]         s1_dx;

    assign {s1_pos, s1_hneg, s1_hzero, s1_base, s1_m, s1_dx} = q1_side;

    // Stage D logic: round half up on magnitudes, length |dx - |v| dt|
    logic [HW-1:0]   hmag_next;
    logic [LW:0]     ldiff_dm;
    logic [LW:0]     ldiff_md;
    logic            lneg_next;
    logic [DXFW-1:0] dxf1;

    always_comb
    begin
        logic rnd1;
        rnd1      = ({q1_rem, 1'b0} >= {1'b0, q1_den});
        hmag_next = q1_quo + {{(Q1-1){1'b0}}, rnd1};
        dxf1      = {s1_dx, {FRACTION_BITS{1'b0}}};
        ldiff_dm  = (LW+1)'(dxf1) - (LW+1)'(s1_m);
        ldiff_md  = (LW+1)'(s1_m) - (LW+1)'(dxf1);
        lneg_next = ldiff_dm[LW];
    end

    // Divider 2: h*L / (2 dx)
    logic [CW-1:0]  ptop;
    logic           ovf_next;
    logic [S2W-1:0] side2_in;
    logic           q2_vld;
    logic [Q2-1:0]  q2_quo;
    logic [D2W-1:0] q2_rem;
    logic [D2W-1:0] q2_den;
    logic [S2W-1:0] q2_side;

    assign ptop     = CW'(f_prod_reg[PW-1:Q2]);
    assign ovf_next = (ptop >= CW'(f_d2_reg));
    assign side2_in = {f_pos_reg, f_skip_reg, f_neg_reg, ovf_next, f_base_reg};

    vlr_div_pipe #(
        .QUO_WIDTH  (Q2),
        .DEN_WIDTH  (D2W),
        .SIDE_WIDTH (S2W)
    ) u_div_corr (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (f_vld_reg),
        .in_rem   (ptop[D2W-1:0]),
        .in_num   (f_prod_reg[Q2-1:0]),
        .in_den   (f_d2_reg),
        .in_side  (side2_in),
        .out_vld  (q2_vld),
        .out_quo  (q2_quo),
        .out_rem  (q2_rem),
        .out_den  (q2_den),
        .out_side (q2_side)
    );

    logic                   s2_pos;
    logic                   s2_skip;
    logic                   s2_neg;
    logic                   s2_ovf;
    logic [VALUE_WIDTH-1:0] s2_base;
    logic                   rnd2;

    assign {s2_pos, s2_skip, s2_neg, s2_ovf, s2_base} = q2_side;
    assign rnd2 = ({q2_rem, 1'b0} >= {1'b0, q2_den});

    // Stage J logic: clip correction magnitude
    logic [CMW-1:0] cm_next;

    always_comb
    begin
        if (h_skip_reg)
        begin
            cm_next = '0;
        end
        else if (h_ovf_reg || (h_q2r_reg > (Q2+1)'(CAP)))
        begin
            cm_next = CAP;
        end
        else
        begin
            cm_next = h_q2r_reg[CMW-1:0];
        end
    end

    // Stage K logic: signed sum and saturation
    logic [RW-1:0]          sum;
    logic                   over;
    logic [VALUE_WIDTH-1:0] res_next;

    always_comb
    begin
        logic [RW-1:0] bx;
        logic [RW-1:0] cx;
        bx   = {{4{j_base_reg[VALUE_WIDTH-1]}}, j_base_reg};
        cx   = {2'b00, j_cm_reg};
        sum  = j_sub_reg ? (bx - cx) : (bx + cx);
        over = (sum[RW-1:VALUE_WIDTH-1] != '0) && (sum[RW-1:VALUE_WIDTH-1] != '1);
        if (over)
        begin
            res_next = sum[RW-1] ? MIN_VAL : MAX_VAL;
        end
        else
        begin
            res_next = sum[VALUE_WIDTH-1:0];
        end
    end

    // Valid bits of the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
            e_vld_reg <= 1'b0;
            f_vld_reg <= 1'b0;
            h_vld_reg <= 1'b0;
            j_vld_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            a_vld_reg <= start;
            b_vld_reg <= a_vld_reg;
            d_vld_reg <= q1_vld;
            e_vld_reg <= d_vld_reg;
            f_vld_reg <= e_vld_reg;
            h_vld_reg <= q2_vld;
            j_vld_reg <= h_vld_reg;
            done_reg  <= j_vld_reg;
        end
    end

    // Payload of the pipeline
    always_ff @(posedge clk)
    begin
        // A
        a_pos_reg   <= a_pos_next;
        a_hneg_reg  <= dif_a[MW-1];
        a_hzero_reg <= hzero_next;
        a_base_reg  <= base_next;
        a_ma_reg    <= ma_next;
        a_mb_reg    <= mb_next;
        a_vmag_reg  <= vmag_next;
        a_dx_reg    <= cell_width;
        // B
        b_pos_reg   <= a_pos_reg;
        b_hneg_reg  <= a_hneg_reg;
        b_hzero_reg <= a_hzero_reg;
        b_base_reg  <= a_base_reg;
        b_prod_reg  <= a_ma_reg * a_mb_reg;
        b_den_reg   <= {1'b0, a_ma_reg} + {1'b0, a_mb_reg};
        b_m_reg     <= a_vmag_reg * ts_reg;
        b_dx_reg    <= a_dx_reg;
        // D
        d_pos_reg   <= s1_pos;
        d_skip_reg  <= s1_hzero || (s1_dx == '0);
        d_neg_reg   <= s1_hneg ^ lneg_next;
        d_base_reg  <= s1_base;
        d_hmag_reg  <= hmag_next;
        d_len_reg   <= lneg_next ? ldiff_md[LW-1:0] : ldiff_dm[LW-1:0];
        d_dx_reg    <= s1_dx;
        // E
        e_pos_reg   <= d_pos_reg;
        e_skip_reg  <= d_skip_reg;
        e_neg_reg   <= d_neg_reg;
        e_base_reg  <= d_base_reg;
        e_pplo_reg  <= d_hmag_reg * d_len_reg[LS-1:0];
        e_pphi_reg  <= d_hmag_reg * d_len_reg[LW-1:LS];
        e_dx_reg    <= d_dx_reg;
        // F
        f_pos_reg   <= e_pos_reg;
        f_skip_reg  <= e_skip_reg;
        f_neg_reg   <= e_neg_reg;
        f_base_reg  <= e_base_reg;
        f_prod_reg  <= PW'(e_pplo_reg) + (PW'(e_pphi_reg) << LS);
        f_d2_reg    <= {e_dx_reg, {FRACTION_BITS{1'b0}}, 1'b0};
        // H
        h_pos_reg   <= s2_pos;
        h_skip_reg  <= s2_skip;
        h_neg_reg   <= s2_neg;
        h_ovf_reg   <= s2_ovf;
        h_base_reg  <= s2_base;
        h_q2r_reg   <= (Q2+1)'(q2_quo) + (Q2+1)'(rnd2);
        // J
        j_sub_reg   <= !(h_pos_reg ^ h_neg_reg);
        j_base_reg  <= h_base_reg;
        j_cm_reg    <= cm_next;
        // K
        interface_value_reg <= res_next;
        saturated_reg       <= over;
    end

    assign done            = done_reg;
    assign interface_value = interface_value_reg;
    assign saturated       = saturated_reg;

`ifndef SYNTHESIS
    // Every accepted word gives exactly one result after the fixed latency
    assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LATENCY done)
        else $error("result missing after accepted word");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("result without accepted word");

    // A clipped result sits on a range limit
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && saturated) |-> (interface_value == MAX_VAL || interface_value == MIN_VAL))
        else $error("saturated flag with in-range value");

    // Flat left neighbour with positive velocity gives the upwind value unchanged
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && (velocity > 0) && (value_left == value_two_left)) |->
            ##LATENCY ((interface_value == $past(value_left, LATENCY)) && !saturated))
        else $error("zero slope did not return upwind value");
`endif

endmodule

@@ tb/van_leer_x_interface_reconstruct_core_tb.sv @@
// Self-checking testbench for the van Leer x-interface reconstruction core.
`timescale 1ns / 1ps

module van_leer_x_interface_reconstruct_core_tb;

    localparam int LATENCY = 2 * vlr_pkg::VALUE_WIDTH + 12;
    localparam logic signed [31:0] VMAX = 32'sh7fffffff;
    localparam logic signed [31:0] VMIN = 32'sh80000000;

    typedef struct packed {
        logic signed [31:0] value;
        logic               sat;
    } iface_word_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [30:0] cfg_data;
    logic        start;
    logic        busy;
    logic signed [31:0] value_two_left, value_left, value_here, value_right, velocity;
    logic [30:0] cell_width;
    logic        done;
    logic signed [31:0] interface_value;
    logic        saturated;

    logic [30:0] dt_model;
    iface_word_t pending_words[$];
    int          error_count;

    van_leer_x_interface_reconstruct_core dut (
        .clk(clk), .rst_n(rst_n), .cfg_write(cfg_write), .cfg_data(cfg_data),
        .start(start), .busy(busy),
        .value_two_left(value_two_left), .value_left(value_left),
        .value_here(value_here), .value_right(value_right),
        .velocity(velocity), .cell_width(cell_width),
        .done(done), .interface_value(interface_value), .saturated(saturated)
    );

    // Clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Rounded quotient, half away from zero, for non-negative operands
    function automatic logic [255:0] div_round(input logic [255:0] n, input logic [255:0] d);
        logic [255:0] q;
        logic [255:0] r;
        q = n / d;
        r = n % d;
        if (r >= d - r)
            q = q + 1;
        return q;
    endfunction

    // Predicted interface word for one stencil
    function automatic iface_word_t reconstruct(
        input logic signed [31:0] q2l, input logic signed [31:0] ql,
        input logic signed [31:0] qh, input logic signed [31:0] qr,
        input logic signed [31:0] vel, input logic [30:0] dx, input logic [30:0] dt);
        iface_word_t w;
        logic signed [63:0] a, b, upw, corr, res;
        logic [255:0] ma, mb, hm, mv, dxf, len, cm, capv;
        logic pos, hneg, lneg;
        pos  = vel > 0;
        upw  = pos ? 64'(ql) : 64'(qh);
        a    = pos ? 64'(ql) - 64'(q2l) : 64'(qh) - 64'(ql);
        b    = pos ? 64'(qh) - 64'(ql) : 64'(qr) - 64'(qh);
        hneg = a < 0;
        corr = 0;
        hm   = '0;
        if (a != 0 && b != 0 && ((a < 0) == (b < 0)))
        begin
            ma = 256'(a < 0 ? -a : a);
            mb = 256'(b < 0 ? -b : b);
            hm = div_round((ma << 1) * mb, ma + mb);
        end
        if (hm != 0 && dx != 0)
        begin
            dxf  = 256'(dx) << vlr_pkg::FRACTION_BITS;
            mv   = 256'(vel < 0 ? -64'(vel) : 64'(vel)) * 256'(dt);
            lneg = mv > dxf;
            len  = lneg ? mv - dxf : dxf - mv;
            capv = 256'(1) << (vlr_pkg::VALUE_WIDTH + 1);
            cm   = div_round(hm * len, dxf << 1);
            if (cm > capv)
                cm = capv;
            corr = (hneg != lneg) ? -64'(cm) : 64'(cm);
        end
        res   = pos ? upw + corr : upw - corr;
        w.sat = 1'b0;
        if (res > 64'(VMAX))
        begin
            res = VMAX;
            w.sat = 1'b1;
        end
        if (res < 64'(VMIN))
        begin
            res = VMIN;
            w.sat = 1'b1;
        end
        w.value = res[31:0];
        return w;
    endfunction

    // Result checker: every strobe must match the oldest expected word
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_words.size() == 0)
            begin
                $error("unexpected word: interface_value %0d", interface_value);
                error_count++;
            end
            else
            begin
                iface_word_t e;
                e = pending_words.pop_front();
                if (interface_value !== e.value)
                begin
                    $error("interface_value expected %0d actual %0d", e.value, interface_value);
                    error_count++;
                end
                if (saturated !== e.sat)
                begin
                    $error("saturated expected %0b actual %0b", e.sat, saturated);
                    error_count++;
                end
            end
        end
    end

    // Send one word, with a random gap before it when gaps is set
    task automatic send_word(input logic signed [31:0] q2l, input logic signed [31:0] ql,
                             input logic signed [31:0] qh, input logic signed [31:0] qr,
                             input logic signed [31:0] vel, input logic [30:0] dx,
                             input bit gaps);
        int idle;
        idle = gaps ? $urandom_range(0, 11) : 0;
        if (idle > 0)
        begin
            start <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        start          <= 1'b1;
        value_two_left <= q2l;
        value_left     <= ql;
        value_here     <= qh;
        value_right    <= qr;
        velocity       <= vel;
        cell_width     <= dx;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_words.push_back(reconstruct(q2l, ql, qh, qr, vel, dx, dt_model));
    endtask

    // Drain the pipeline then write the time step
    task automatic set_time_step(input logic [30:0] dt);
        start <= 1'b0;
        @(posedge clk);
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= dt;
        @(posedge clk);
        cfg_write <= 1'b0;
        dt_model   = dt;
    endtask

    function automatic logic [31:0] rand_value(input int mode);
        case (mode)
            0: return $urandom_range(0, 1) ? VMAX : VMIN;
            1: return 32'($signed($urandom_range(0, 8'hff)) - 128) <<< vlr_pkg::FRACTION_BITS;
            2: return 32'($signed($urandom_range(0, 20'hfffff)) - 20'sh80000);
            default: return $urandom;
        endcase
    endfunction

    // Extremes, both upwind directions, zero velocity, flat and opposing slopes
    task automatic test_directed();
        set_time_step(31'h0001_0000);
        send_word(0, 32'h1_0000, 32'h2_0000, 32'h3_0000, 32'h1_0000, 31'h1_0000, 0);
        send_word(0, 32'h1_0000, 32'h2_0000, 32'h3_0000, -32'sh1_0000, 31'h1_0000, 0);
        send_word(0, 32'h1_0000, 32'h2_0000, 32'h3_0000, 0, 31'h1_0000, 0);
        send_word(0, 32'h2_0000, 32'h1_0000, 32'h3_0000, 32'h8000, 31'h1_0000, 0);
        send_word(0, 32'h1_0000, 32'h1_0000, 32'h3_0000, -32'sh8000, 31'h1_0000, 0);
        send_word(0, 32'h1_0000, 32'h2_0000, 32'h3_0000, 32'h1_0000, 31'h0, 0);
        send_word(VMIN, 0, VMAX, VMAX, 32'h1, 31'h1, 0);
        send_word(VMIN, VMIN, 0, VMAX, VMIN, 31'h1, 0);
        send_word(VMAX, 0, VMIN, VMIN, VMAX, 31'h7fff_ffff, 0);
        send_word(VMIN, VMIN + 1, VMAX - 1, VMAX, VMAX, 31'h7fff_ffff, 0);
        send_word(VMAX, VMAX, VMAX, VMAX, VMIN, 31'h7fff_ffff, 0);
        send_word(-1, 0, 1, 2, -1, 31'h1, 0);
        set_time_step(31'h7fff_ffff);
        send_word(0, 32'h1_0000, 32'h2_0000, 32'h4_0000, VMAX, 31'h1_0000, 0);
        send_word(0, 32'h1_0000, 32'h2_0000, 32'h4_0000, VMIN, 31'h1, 0);
        send_word(VMIN, 0, VMAX, VMAX, 32'h1_0000, 31'h1, 0);
        set_time_step(31'h0);
        send_word(0, 32'h1_0000, 32'h2_0000, 32'h4_0000, 32'h1_0000, 31'h1_0000, 0);
        send_word(0, 32'h1_0000, 32'h2_0000, 32'h4_0000, -32'sh1_0000, 31'h1_0000, 0);
    endtask

    // Random stencils over several time steps, mostly monotone so the limiter acts
    task automatic test_random(input int count);
        logic [30:0] steps[5];
        logic signed [31:0] c0, d1, d2, d3;
        logic [30:0] dx;
        int mode;
        steps = '{31'h0, 31'h7fff_ffff, 31'h0000_4000, 31'h0001_0000, 31'h0};
        for (int ph = 0; ph < 5; ph++)
        begin
            set_time_step(ph == 4 ? 31'($urandom) : steps[ph]);
            for (int n = 0; n < count / 5; n++)
            begin
                mode = $urandom_range(0, 3);
                c0 = rand_value(mode);
                if ($urandom_range(0, 3) != 0)
                begin
                    // monotone stencil with random direction and step sizes
                    d1 = 32'($urandom_range(1, 32'h4_0000));
                    d2 = 32'($urandom_range(1, 32'h4_0000));
                    d3 = 32'($urandom_range(1, 32'h4_0000));
                    if ($urandom_range(0, 1))
                    begin
                        d1 = -d1;
                        d2 = -d2;
                        d3 = -d3;
                    end
                    c0 = rand_value(1 + $urandom_range(0, 1));
                    d1 = c0 + d1;
                    d2 = d1 + d2;
                    d3 = d2 + d3;
                    send_word(c0, d1, d2, d3, rand_value($urandom_range(1, 3)),
                              $urandom_range(0, 7) == 0 ? 31'($urandom)
                                                        : 31'($urandom_range(1, 31'h4_0000)), 1);
                end
                else
                begin
                    dx = $urandom_range(0, 15) == 0 ? 31'h0 : 31'($urandom);
                    send_word(rand_value(mode), rand_value($urandom_range(0, 3)),
                              rand_value($urandom_range(0, 3)), rand_value($urandom_range(0, 3)),
                              rand_value($urandom_range(0, 3)), dx, $urandom_range(0, 3) != 0);
                end
            end
        end
    endtask

    // Stimulus
    initial
    begin
        error_count    = 0;
        dt_model       = '0;
        rst_n          = 1'b0;
        cfg_write      = 1'b0;
        cfg_data       = '0;
        start          = 1'b0;
        value_two_left = '0;
        value_left     = '0;
        value_here     = '0;
        value_right    = '0;
        velocity       = '0;
        cell_width     = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(1650);
        start <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (error_count == 0)
            $display("PASS van_leer_x_interface_reconstruct_core");
        else
            $display("FAIL van_leer_x_interface_reconstruct_core");
        $finish;
    end

    // Timeout
    initial
    begin
        #2_000_000;
        $display("FAIL van_leer_x_interface_reconstruct_core");
        $finish;
    end

endmodule
